// ===== rtl/sensor_gap_interpolator_macros.svh =====
// ============================================================================
// Assertion macros for the sensor gap interpolator
// Implication and next-cycle checks; define ASSERT_OFF to drop them all.
// ============================================================================
`ifndef SENSOR_GAP_INTERPOLATOR_MACROS_SVH
`define SENSOR_GAP_INTERPOLATOR_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SGI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sensor gap interpolator: check failed");

// next-cycle implication
`define SGI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sensor gap interpolator: check failed");

`else

`define SGI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SGI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/sgi_pkg.sv =====
// ============================================================================
// sgi_pkg
// Shared constants, word types and controller/datapath interface structs.
// ============================================================================
package sgi_pkg;

    localparam int SENSORS   = 16;
    localparam int MAX_GAP   = 64;

    localparam int ID_W      = 4;
    localparam int TIME_W    = 32;
    localparam int TEMP_W    = 16;

    // index into the per-sensor store
    localparam int SIDX_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    // gap length 1..MAX_GAP
    localparam int GAP_W     = $clog2(MAX_GAP + 1);
    // |delta| fits TEMP_W bits, one quotient bit per step
    localparam int DIV_STEPS = TEMP_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [ID_W-1:0]          sensor_id;
        logic [TIME_W-1:0]        timestamp;
        logic signed [TEMP_W-1:0] temperature;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]          out_sensor;
        logic [TIME_W-1:0]        out_time;
        logic signed [TEMP_W-1:0] out_temperature;
        logic                     interpolated;
        logic                     gap_too_long;
        logic                     last_of_run;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture input word
        logic stale_upd;  // stale tick: refresh stored value only
        logic pass;       // emit reading unchanged, update store
        logic div_start;  // set up gap fill, start divider
        logic div_step;   // one quotient bit
        logic step;       // emit one gap-fill word
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ignore;     // sensor index out of range
        logic first;      // sensor not seen yet
        logic stale;      // tick not after stored tick
        logic pass;       // gap of one, or over MAX_GAP
        logic div_done;
        logic last_step;
        logic out_free;   // output register can take a word
    } t_status;

endpackage

// ===== rtl/sgi_dpath.sv =====
// ============================================================================
// sgi_dpath
// Per-sensor store, serial divider, step accumulators and output register.
// ============================================================================
module sgi_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgi_pkg::t_cmd     i_cmd,
    output sgi_pkg::t_status  o_status,
    input  sgi_pkg::t_in_word i_in,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output sgi_pkg::t_out_word o_out
);
    import sgi_pkg::*;

    // per-sensor store
    logic                  r_seen      [SENSORS];
    logic [TIME_W-1:0]     r_last_time [SENSORS];
    logic [TEMP_W-1:0]     r_last_val  [SENSORS];

    t_in_word              r_in;

    // gap-fill working set
    logic [TEMP_W-1:0]     r_base;
    logic                  r_neg;
    logic [GAP_W-1:0]      r_n;
    logic [TEMP_W-1:0]     r_quo;
    logic [GAP_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic [GAP_W-1:0]      r_k;
    logic [TEMP_W-1:0]     r_acc_q;
    logic [GAP_W-1:0]      r_acc_r;
    logic [TIME_W-1:0]     r_time;

    logic                  r_out_valid;
    t_out_word             r_out;

    logic [SIDX_W-1:0]     w_idx;
    logic                  w_seen;
    logic [TIME_W-1:0]     w_ltime;
    logic [TEMP_W-1:0]     w_lval;
    logic [TIME_W-1:0]     w_gap;
    logic                  w_stale;
    logic                  w_pass;
    logic [TEMP_W:0]       w_delta;
    logic [TEMP_W:0]       w_delta_abs;

    logic [GAP_W:0]        w_trial;
    logic [GAP_W:0]        w_trial_sub;
    logic                  w_fits;

    logic [GAP_W:0]        w_sum_r;
    logic [GAP_W:0]        w_sum_r_sub;
    logic                  w_wrap;
    logic [GAP_W-1:0]      w_next_r;
    logic [TEMP_W-1:0]     w_next_q;
    logic [TEMP_W+1:0]     w_base_x;
    logic [TEMP_W+1:0]     w_mag_x;
    logic [TEMP_W+1:0]     w_val;
    logic                  w_last_step;
    logic                  w_out_free;
    logic                  w_load;

    // store lookup
    assign w_idx   = SIDX_W'(r_in.sensor_id);
    assign w_seen  = r_seen[w_idx];
    assign w_ltime = r_last_time[w_idx];
    assign w_lval  = r_last_val[w_idx];

    assign w_gap   = r_in.timestamp - w_ltime;
    assign w_stale = (r_in.timestamp <= w_ltime);
    assign w_pass  = (w_gap == TIME_W'(1)) || (w_gap > TIME_W'(MAX_GAP));

    assign w_delta     = {r_in.temperature[TEMP_W-1], r_in.temperature}
                       - {w_lval[TEMP_W-1], w_lval};
    assign w_delta_abs = w_delta[TEMP_W] ? (~w_delta + 1'b1) : w_delta;

    // restoring divider, |delta| / n
    assign w_trial     = {r_rem, r_quo[TEMP_W-1]};
    assign w_trial_sub = w_trial - {1'b0, r_n};
    assign w_fits      = (w_trial >= {1'b0, r_n});

    // trunc(|delta|*k/n) built up as k*q + carries of k*r over n
    assign w_sum_r     = {1'b0, r_acc_r} + {1'b0, r_rem};
    assign w_sum_r_sub = w_sum_r - {1'b0, r_n};
    assign w_wrap      = (w_sum_r >= {1'b0, r_n});
    assign w_next_r    = w_wrap ? w_sum_r_sub[GAP_W-1:0] : w_sum_r[GAP_W-1:0];
    assign w_next_q    = r_acc_q + r_quo + TEMP_W'(w_wrap);

    assign w_base_x    = {{2{r_base[TEMP_W-1]}}, r_base};
    assign w_mag_x     = {2'b00, w_next_q};
    assign w_val       = r_neg ? (w_base_x - w_mag_x) : (w_base_x + w_mag_x);

    assign w_last_step = (r_k == r_n);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = i_cmd.pass || i_cmd.step;

    always_comb begin
        o_status           = '0;
        o_status.ignore    = (32'(r_in.sensor_id) >= SENSORS);
        o_status.first     = !w_seen;
        o_status.stale     = w_stale;
        o_status.pass      = w_pass;
        o_status.div_done  = (r_cnt == '0);
        o_status.last_step = w_last_step;
        o_status.out_free  = w_out_free;
    end

    // seen flags, output valid and divider count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENSORS; s++) begin
                r_seen[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.pass) begin
                r_seen[w_idx] <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.div_start) begin
                r_cnt <= CNT_W'(DIV_STEPS);
            end else if (i_cmd.div_step && (r_cnt != '0)) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // store contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass || (i_cmd.step && w_last_step)) begin
            r_last_time[w_idx] <= r_in.timestamp;
            r_last_val[w_idx]  <= r_in.temperature;
        end else if (i_cmd.stale_upd) begin
            r_last_val[w_idx]  <= r_in.temperature;
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_in;
        end

        if (i_cmd.div_start) begin
            r_n     <= w_gap[GAP_W-1:0];
            r_base  <= w_lval;
            r_neg   <= w_delta[TEMP_W];
            r_quo   <= w_delta_abs[TEMP_W-1:0];
            r_rem   <= '0;
            r_acc_q <= '0;
            r_acc_r <= '0;
            r_k     <= GAP_W'(1);
            r_time  <= w_ltime;
        end else if (i_cmd.div_step && (r_cnt != '0)) begin
            r_quo <= {r_quo[TEMP_W-2:0], w_fits};
            r_rem <= w_fits ? w_trial_sub[GAP_W-1:0] : w_trial[GAP_W-1:0];
        end else if (i_cmd.step) begin
            r_acc_q <= w_next_q;
            r_acc_r <= w_next_r;
            r_k     <= r_k + 1'b1;
            r_time  <= r_time + 1'b1;
        end

        if (i_cmd.pass) begin
            r_out.out_sensor      <= r_in.sensor_id;
            r_out.out_time        <= r_in.timestamp;
            r_out.out_temperature <= r_in.temperature;
            r_out.interpolated    <= 1'b0;
            r_out.gap_too_long    <= w_seen && (w_gap != TIME_W'(1));
            r_out.last_of_run     <= 1'b1;
        end else if (i_cmd.step) begin
            r_out.out_sensor      <= r_in.sensor_id;
            r_out.out_time        <= r_time + 1'b1;
            r_out.out_temperature <= w_val[TEMP_W-1:0];
            r_out.interpolated    <= !w_last_step;
            r_out.gap_too_long    <= 1'b0;
            r_out.last_of_run     <= w_last_step;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/sgi_ctrl.sv =====
// ============================================================================
// sgi_ctrl
// Sequencer: classify the reading, run the divider, pace the output words.
// ============================================================================
module sgi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sgi_pkg::t_status i_status,
    output sgi_pkg::t_cmd    o_cmd
);
    import sgi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_PASS = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.ignore) begin
                    n_state = S_IDLE;
                end else if (i_status.first) begin
                    n_state = S_PASS;
                end else if (i_status.stale) begin
                    o_cmd.stale_upd = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_status.pass) begin
                    n_state = S_PASS;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_PASS: begin
                if (i_status.out_free) begin
                    o_cmd.pass = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/sensor_gap_interpolator.sv =====
// ============================================================================
// sensor_gap_interpolator
// Fills tick gaps in per-sensor temperature readings by linear interpolation.
// ============================================================================
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------
//  input    | in        | i_valid / o_stall  | i_data (t_in_word)
//  output   | out       | o_valid / i_stall  | o_data (t_out_word)
//
//  One word at a time. Pass-through and first readings go through EVAL and
//  PASS, a stale reading through EVAL only; a gap of n ticks runs the
//  bit-serial divider (one quotient bit a cycle, 16 bits), then emits n
//  words from the step accumulators, one output word a cycle while not stalled.
//  Reset is synchronous, active low; it clears the seen flags at once,
//  no clearing pass. Stored ticks and values are only read once seen.
//  A stall on the output holds the current word; the next input word is
//  taken as soon as the last result of the run sits in the output register.
//
module sensor_gap_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sgi_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output sgi_pkg::t_out_word o_data
);
    import sgi_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;

    sgi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // store, divider, accumulators and the output register
    sgi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_data),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out       (o_data)
    );

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
`include "sensor_gap_interpolator_macros.svh"

    // an accepted word keeps the input stalled while it is worked on
    `SGI_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // a word is only loaded when the output register can take it
    `SGI_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, w_cmd.step || w_cmd.pass, w_status.out_free)

    // closing step of a gap run shows as the final word of the run
    `SGI_ASSERT_NXT(a_run_end_flag, i_clk, i_rst_n,
                    w_cmd.step && w_status.last_step, o_valid && o_data.last_of_run)

    // an unfilled long gap is a single, real reading
    `SGI_ASSERT_IMP(a_long_gap_alone, i_clk, i_rst_n,
                    o_valid && o_data.gap_too_long,
                    !o_data.interpolated && o_data.last_of_run)

endmodule
